/* rtl/core/cpdm_pkg.sv */
// Shared types, widths and register indexes for the dual motor PI controller.
// Used by cpdm_mac and by the top level cascaded_pi_dual_motor_pwm.
package cpdm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_VEL_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_KP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_KI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_MODE = 3'd6;

	localparam logic [CFG_DATA_W-1:0] LIMIT_RESET  = 16'd7200;
	localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 16'd7200;

	localparam int ERR_W   = 33;
	localparam int DIFF_W  = 34;
	localparam int DRV_W   = 17;
	localparam int MUL_A_W = DIFF_W;
	localparam int MUL_B_W = CFG_DATA_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int SUM_W   = ACC_W + 1;

	localparam int OUT_RAW_W = 4 * 16 + 2 * DRV_W + 2 * 32;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef struct packed {
		logic mul;
		logic load;
		logic add;
	} mac_ctrl_t;

endpackage

/* rtl/core/cpdm_mac.sv */
// Shared multiply-accumulate unit: one registered product and an accumulator.
// Depends on cpdm_pkg for the operand widths and the control struct.
module cpdm_mac (
	input  logic                                clk,
	input  cpdm_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [cpdm_pkg::MUL_A_W-1:0] a,
	input  logic signed [cpdm_pkg::MUL_B_W-1:0] b,
	output logic signed [cpdm_pkg::ACC_W-1:0]   acc
);
	import cpdm_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= a * b;
		end
		if (ctrl.load) begin
			acc_q <= ACC_W'(prod_q);
		end else if (ctrl.add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/core/cascaded_pi_dual_motor_pwm.sv */
// Top level of the cascaded PI controller for two motors with H-bridge compares.
// Depends on cpdm_pkg and on the shared multiply-accumulate unit cpdm_mac.
//
// Channel  Direction  Handshake           Content
// cfg      in         cfg_we              register index and write data
// s        in         s_tvalid/s_tready   encoder deltas and goals of one tick
// m        out        m_tvalid/m_tready   compares, drives and positions
//
// Per motor, a tick runs the position then the velocity states in position mode and
// only the velocity states otherwise; the single shared multiplier sets this.
// s_tready is high only while the sequencer is idle; a finished word waits in the
// output register and the next tick is accepted meanwhile.
// Reset clears motor state and restores configuration defaults at once.
module cascaded_pi_dual_motor_pwm #(
	parameter int MOTOR_COUNT    = 2,
	parameter int ENC_BITS       = 16,
	parameter int GAIN_FRAC_BITS = 8,
	localparam int IN_W = ((2 * ENC_BITS + 64 + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cpdm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [cpdm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// enc_delta_left, enc_delta_right, goal_left, goal_right
	input  logic [IN_W-1:0]                    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// left_cmp_a, left_cmp_b, right_cmp_a, right_cmp_b, drive_left, drive_right,
	// position_left, position_right
	output logic [cpdm_pkg::OUT_W-1:0]         m_tdata
);
	import cpdm_pkg::*;

	localparam int ACTIVE = (MOTOR_COUNT < 2) ? MOTOR_COUNT : 2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_POS  = 4'd1;
	localparam logic [3:0] ST_PERR = 4'd2;
	localparam logic [3:0] ST_PDIF = 4'd3;
	localparam logic [3:0] ST_PMA  = 4'd4;
	localparam logic [3:0] ST_PMB  = 4'd5;
	localparam logic [3:0] ST_PMC  = 4'd6;
	localparam logic [3:0] ST_PUPD = 4'd7;
	localparam logic [3:0] ST_VERR = 4'd8;
	localparam logic [3:0] ST_VDIF = 4'd9;
	localparam logic [3:0] ST_VMA  = 4'd10;
	localparam logic [3:0] ST_VMB  = 4'd11;
	localparam logic [3:0] ST_VMC  = 4'd12;
	localparam logic [3:0] ST_VUPD = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	logic [CFG_DATA_W-1:0] vel_kp_q, vel_ki_q, pos_kp_q, pos_ki_q;
	logic [CFG_DATA_W-1:0] limit_q, period_q;
	logic                  pos_mode_q;

	logic [3:0] state_q;
	logic       motor_q;

	logic signed [31:0]       pos_q      [ACTIVE];
	logic signed [31:0]       speed_q    [ACTIVE];
	logic signed [DRV_W-1:0]  drive_q    [ACTIVE];
	logic signed [ERR_W-1:0]  prev_se_q  [ACTIVE];
	logic signed [ERR_W-1:0]  prev_pe_q  [ACTIVE];

	logic signed [ENC_BITS-1:0] enc_q  [2];
	logic signed [31:0]         goal_q [2];
	logic signed [ERR_W-1:0]    err_q;
	logic signed [DIFF_W-1:0]   diff_q;

	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic signed [ERR_W-1:0] enc_ext;
	mac_ctrl_t               mac_ctrl;
	logic signed [MUL_A_W-1:0] mac_a;
	logic signed [MUL_B_W-1:0] mac_b;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_sh;
	logic signed [SUM_W-1:0]   spd_sum, drv_sum, lim_s;
	logic signed [31:0]        spd_new;
	logic signed [DRV_W-1:0]   drv_new;
	logic                      spd_ovf;

	logic [15:0]             o_cmp_a [2];
	logic [15:0]             o_cmp_b [2];
	logic signed [DRV_W-1:0] o_drive [2];
	logic signed [31:0]      o_pos   [2];

	assign enc_ext = ERR_W'(enc_q[motor_q]);
	assign acc_sh  = acc >>> GAIN_FRAC_BITS;

	always_comb begin
		mac_ctrl = '0;
		mac_a    = MUL_A_W'(err_q);
		mac_b    = {1'b0, vel_ki_q};
		case (state_q)
			ST_PMA: begin
				mac_ctrl.mul = 1'b1;
				mac_a        = diff_q;
				mac_b        = {1'b0, pos_kp_q};
			end
			ST_PMB: begin
				mac_ctrl.mul  = 1'b1;
				mac_ctrl.load = 1'b1;
				mac_b         = {1'b0, pos_ki_q};
			end
			ST_VMA: begin
				mac_ctrl.mul = 1'b1;
				mac_a        = diff_q;
				mac_b        = {1'b0, vel_kp_q};
			end
			ST_VMB: begin
				mac_ctrl.mul  = 1'b1;
				mac_ctrl.load = 1'b1;
			end
			ST_PMC, ST_VMC: begin
				mac_ctrl.add = 1'b1;
			end
			default: begin
				mac_ctrl = '0;
			end
		endcase
	end

	cpdm_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.a    (mac_a),
		.b    (mac_b),
		.acc  (acc)
	);

	always_comb begin
		spd_sum = SUM_W'(speed_q[motor_q]) + SUM_W'(acc_sh);
		spd_ovf = (spd_sum[SUM_W-1:31] != {(SUM_W-31){spd_sum[31]}});
		if (spd_ovf) begin
			spd_new = spd_sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			spd_new = spd_sum[31:0];
		end
		drv_sum = SUM_W'(drive_q[motor_q]) + SUM_W'(acc_sh);
		lim_s   = $signed(SUM_W'(limit_q));
		if (drv_sum > lim_s) begin
			drv_new = lim_s[DRV_W-1:0];
		end else if (drv_sum < -lim_s) begin
			drv_new = DRV_W'(-lim_s);
		end else begin
			drv_new = drv_sum[DRV_W-1:0];
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_out
		if (g < ACTIVE) begin : g_on
			logic signed [DRV_W:0] rev;
			assign rev = $signed({2'b00, period_q}) + (DRV_W+1)'(drive_q[g]);
			assign o_drive[g] = drive_q[g];
			assign o_pos[g]   = pos_q[g];
			assign o_cmp_a[g] = drive_q[g][DRV_W-1] ? period_q : 16'd0;
			assign o_cmp_b[g] = !drive_q[g][DRV_W-1] ? drive_q[g][15:0] :
				(rev[DRV_W] ? 16'd0 : rev[15:0]);
		end else begin : g_off
			assign o_drive[g] = '0;
			assign o_pos[g]   = '0;
			assign o_cmp_a[g] = '0;
			assign o_cmp_b[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_kp_q   <= '0;
			vel_ki_q   <= '0;
			pos_kp_q   <= '0;
			pos_ki_q   <= '0;
			limit_q    <= LIMIT_RESET;
			period_q   <= PERIOD_RESET;
			pos_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_VEL_KP:   vel_kp_q   <= cfg_wdata;
				CFG_VEL_KI:   vel_ki_q   <= cfg_wdata;
				CFG_POS_KP:   pos_kp_q   <= cfg_wdata;
				CFG_POS_KI:   pos_ki_q   <= cfg_wdata;
				CFG_LIMIT:    limit_q    <= cfg_wdata;
				CFG_PERIOD:   period_q   <= cfg_wdata;
				CFG_POS_MODE: pos_mode_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			enc_q[0]  <= s_tdata[ENC_BITS-1:0];
			enc_q[1]  <= s_tdata[2*ENC_BITS-1:ENC_BITS];
			goal_q[0] <= s_tdata[2*ENC_BITS+31:2*ENC_BITS];
			goal_q[1] <= s_tdata[2*ENC_BITS+63:2*ENC_BITS+32];
		end
		case (state_q)
			ST_PERR: err_q <= ERR_W'(goal_q[motor_q]) - ERR_W'(pos_q[motor_q]);
			ST_VERR: err_q <= ERR_W'(speed_q[motor_q]) - enc_ext;
			ST_PDIF: diff_q <= DIFF_W'(err_q) - DIFF_W'(prev_pe_q[motor_q]);
			ST_VDIF: diff_q <= DIFF_W'(err_q) - DIFF_W'(prev_se_q[motor_q]);
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {(OUT_W-OUT_RAW_W)'(0), o_pos[1], o_pos[0], o_drive[1], o_drive[0],
				o_cmp_b[1], o_cmp_a[1], o_cmp_b[0], o_cmp_a[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			motor_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < ACTIVE; i++) begin
				pos_q[i]     <= '0;
				speed_q[i]   <= '0;
				drive_q[i]   <= '0;
				prev_se_q[i] <= '0;
				prev_pe_q[i] <= '0;
			end
		end else begin
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					motor_q <= 1'b0;
					if (s_tvalid) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					pos_q[motor_q] <= 32'(ERR_W'(pos_q[motor_q]) + enc_ext);
					if (pos_mode_q) begin
						state_q <= ST_PERR;
					end else begin
						speed_q[motor_q] <= goal_q[motor_q];
						state_q          <= ST_VERR;
					end
				end
				ST_PERR: state_q <= ST_PDIF;
				ST_PDIF: begin
					prev_pe_q[motor_q] <= err_q;
					state_q            <= ST_PMA;
				end
				ST_PMA: state_q <= ST_PMB;
				ST_PMB: state_q <= ST_PMC;
				ST_PMC: state_q <= ST_PUPD;
				ST_PUPD: begin
					speed_q[motor_q] <= spd_new;
					state_q          <= ST_VERR;
				end
				ST_VERR: state_q <= ST_VDIF;
				ST_VDIF: begin
					prev_se_q[motor_q] <= err_q;
					state_q            <= ST_VMA;
				end
				ST_VMA: state_q <= ST_VMB;
				ST_VMB: state_q <= ST_VMC;
				ST_VMC: state_q <= ST_VUPD;
				ST_VUPD: begin
					drive_q[motor_q] <= drv_new;
					if (motor_q == 1'(ACTIVE - 1)) begin
						state_q <= ST_DONE;
					end else begin
						motor_q <= 1'b1;
						state_q <= ST_POS;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* dv/tb_cascaded_pi_dual_motor_pwm.sv */
`timescale 1ns / 100ps
// Self-checking bench for cascaded_pi_dual_motor_pwm: streams control ticks, predicts each
// output word with an in-bench copy of both PI loops and compares it field by field.
// Depends on cpdm_pkg and the RTL of cascaded_pi_dual_motor_pwm only.
module tb_cascaded_pi_dual_motor_pwm;
	import cpdm_pkg::*;

	localparam int TICK_W = 96;
	localparam int FRAC = 8;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 12;
	localparam int TICKS_PER_PHASE = 152;
	localparam int REPORT_MAX = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
	localparam longint INT_MAX = 64'sd2147483647;
	localparam longint INT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] pos_r;
		logic [31:0] pos_l;
		logic [16:0] drv_r;
		logic [16:0] drv_l;
		logic [15:0] r_cmp_b;
		logic [15:0] r_cmp_a;
		logic [15:0] l_cmp_b;
		logic [15:0] l_cmp_a;
	} bridge_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// enc_delta_left, enc_delta_right, goal_left, goal_right
	logic [TICK_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// left_cmp_a, left_cmp_b, right_cmp_a, right_cmp_b, drive_left, drive_right,
	// position_left, position_right
	logic [OUT_W-1:0] m_tdata;

	cascaded_pi_dual_motor_pwm dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	logic [15:0] cfg_vel_kp = '0;
	logic [15:0] cfg_vel_ki = '0;
	logic [15:0] cfg_pos_kp = '0;
	logic [15:0] cfg_pos_ki = '0;
	logic [15:0] cfg_limit = LIMIT_RESET;
	logic [15:0] cfg_period = PERIOD_RESET;
	logic cfg_pos_mode = 1'b0;

	logic signed [31:0] pos_acc [2] = '{32'sd0, 32'sd0};
	logic signed [31:0] spd_tgt [2] = '{32'sd0, 32'sd0};
	logic signed [16:0] drv [2] = '{17'sd0, 17'sd0};
	logic signed [32:0] prev_spd_err [2] = '{33'sd0, 33'sd0};
	logic signed [32:0] prev_pos_err [2] = '{33'sd0, 33'sd0};
	logic signed [31:0] plan_pos [2] = '{32'sd0, 32'sd0};

	logic [TICK_W-1:0] tick_queue [$];
	bridge_word_t expected_words [$];
	bridge_word_t got_word;
	bridge_word_t want_word;

	int send_idle = 25;
	int recv_idle = 82;
	int ticks_queued = 0;
	int words_checked = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint pi_update(input longint e, input longint ep,
			input logic [15:0] kp, input logic [15:0] ki);
		longint gk;
		longint gi;
		longint s;
		gk = longint'(kp);
		gi = longint'(ki);
		s = gk * (e - ep) + gi * e;
		return s >>> FRAC;
	endfunction

	task automatic compute_tick(input logic [TICK_W-1:0] tick);
		logic signed [15:0] enc16;
		logic signed [31:0] goal32;
		longint enc, goal, e, ep, t, d, lim, per, ca, cb;
		bridge_word_t w;
		w = '0;
		lim = longint'(cfg_limit);
		per = longint'(cfg_period);
		for (int m = 0; m < 2; m++) begin
			enc16 = tick[16*m +: 16];
			goal32 = tick[32 + 32*m +: 32];
			enc = longint'(enc16);
			goal = longint'(goal32);
			t = longint'(pos_acc[m]);
			t = t + enc;
			pos_acc[m] = t[31:0];
			if (cfg_pos_mode) begin
				t = longint'(pos_acc[m]);
				e = goal - t;
				ep = longint'(prev_pos_err[m]);
				t = longint'(spd_tgt[m]);
				t = t + pi_update(e, ep, cfg_pos_kp, cfg_pos_ki);
				if (t > INT_MAX)
					t = INT_MAX;
				else if (t < INT_MIN)
					t = INT_MIN;
				spd_tgt[m] = t[31:0];
				prev_pos_err[m] = e[32:0];
			end else begin
				spd_tgt[m] = goal32;
			end
			t = longint'(spd_tgt[m]);
			e = t - enc;
			ep = longint'(prev_spd_err[m]);
			d = longint'(drv[m]);
			d = d + pi_update(e, ep, cfg_vel_kp, cfg_vel_ki);
			prev_spd_err[m] = e[32:0];
			if (d > lim)
				d = lim;
			else if (d < -lim)
				d = -lim;
			drv[m] = d[16:0];
			if (d >= 0) begin
				ca = 0;
				cb = d;
			end else begin
				ca = per;
				cb = per + d;
				if (cb < 0)
					cb = 0;
			end
			if (m == 0) begin
				w.l_cmp_a = ca[15:0];
				w.l_cmp_b = cb[15:0];
				w.drv_l = d[16:0];
				w.pos_l = pos_acc[m];
			end else begin
				w.r_cmp_a = ca[15:0];
				w.r_cmp_b = cb[15:0];
				w.drv_r = d[16:0];
				w.pos_r = pos_acc[m];
			end
		end
		expected_words.push_back(w);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("word %0d: %s expected %h, got %h", words_checked, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				compute_tick(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					s_tdata <= tick_queue.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_word = bridge_word_t'(m_tdata[$bits(bridge_word_t)-1:0]);
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("output word with no tick pending: %h", got_word);
				end else begin
					want_word = expected_words.pop_front();
					check_field("left_cmp_a", 32'(want_word.l_cmp_a), 32'(got_word.l_cmp_a));
					check_field("left_cmp_b", 32'(want_word.l_cmp_b), 32'(got_word.l_cmp_b));
					check_field("right_cmp_a", 32'(want_word.r_cmp_a), 32'(got_word.r_cmp_a));
					check_field("right_cmp_b", 32'(want_word.r_cmp_b), 32'(got_word.r_cmp_b));
					check_field("drive_left", 32'(want_word.drv_l), 32'(got_word.drv_l));
					check_field("drive_right", 32'(want_word.drv_r), 32'(got_word.drv_r));
					check_field("position_left", want_word.pos_l, got_word.pos_l);
					check_field("position_right", want_word.pos_r, got_word.pos_r);
					words_checked++;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (ticks_queued != words_checked) begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("no handshake for %0d cycles with %0d words outstanding",
						STALL_LIMIT, ticks_queued - words_checked);
					$display("cascaded_pi_dual_motor_pwm: mismatch");
					$finish;
				end
			end else begin
				stall_cycles <= 0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_VEL_KP: cfg_vel_kp = val;
			CFG_VEL_KI: cfg_vel_ki = val;
			CFG_POS_KP: cfg_pos_kp = val;
			CFG_POS_KI: cfg_pos_ki = val;
			CFG_LIMIT: cfg_limit = val;
			CFG_PERIOD: cfg_period = val;
			CFG_POS_MODE: cfg_pos_mode = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [15:0] vkp, input logic [15:0] vki,
			input logic [15:0] pkp, input logic [15:0] pki, input logic [15:0] lim,
			input logic [15:0] per, input logic [15:0] mode);
		write_reg(CFG_VEL_KP, vkp);
		write_reg(CFG_VEL_KI, vki);
		write_reg(CFG_POS_KP, pkp);
		write_reg(CFG_POS_KI, pki);
		write_reg(CFG_LIMIT, lim);
		write_reg(CFG_PERIOD, per);
		write_reg(CFG_POS_MODE, mode);
		end_writes();
	endtask

	task automatic add_tick(input logic signed [15:0] el, input logic signed [15:0] er,
			input logic signed [31:0] gl, input logic signed [31:0] gr);
		tick_queue.push_back({gr, gl, er, el});
		plan_pos[0] = plan_pos[0] + 32'(el);
		plan_pos[1] = plan_pos[1] + 32'(er);
		ticks_queued++;
	endtask

	task automatic add_random_tick();
		logic signed [15:0] enc [2];
		logic signed [31:0] goal [2];
		int r;
		int ofs;
		r = $urandom_range(99);
		for (int m = 0; m < 2; m++) begin
			if (r < 15) begin
				enc[m] = 16'($urandom);
				goal[m] = $urandom;
			end else begin
				ofs = int'($urandom_range(400)) - 200;
				enc[m] = 16'(ofs);
				if (r < 22)
					enc[m] = 16'($urandom);
				if (cfg_pos_mode) begin
					goal[m] = plan_pos[m] + 32'(enc[m]);
					ofs = int'($urandom_range(4000)) - 2000;
					goal[m] = goal[m] + ofs;
				end else begin
					ofs = int'($urandom_range(600)) - 300;
					goal[m] = ofs;
				end
			end
		end
		add_tick(enc[0], enc[1], goal[0], goal[1]);
	endtask

	task automatic wait_drained();
		while (ticks_queued != words_checked)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_gain(input int small_max);
		if ($urandom_range(3) == 0)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(small_max));
	endfunction

	initial begin
		logic [15:0] lim;
		logic [15:0] mode_word;
		int missing;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Velocity mode at the reset clamp and period, field extremes.
		apply_setting(16'd256, 16'd32, 16'd0, 16'd0, LIMIT_RESET, PERIOD_RESET, 16'd0);
		add_tick(16'sd0, 16'sd0, 32'sd0, 32'sd0);
		add_tick(16'sh7fff, 16'sh8000, 32'sd100, -32'sd100);
		add_tick(16'sh8000, 16'sh7fff, 32'sh7fffffff, 32'sh80000000);
		add_tick(16'sd1, -16'sd1, 32'sh80000000, 32'sh7fffffff);
		add_tick(16'sd0, 16'sd0, 32'sd0, 32'sd0);
		wait_drained();

		// Full gains: velocity target saturates both ways, reverse compare floors at zero.
		apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1, 16'd1);
		add_tick(16'sd0, 16'sd0, 32'sh7fffffff, 32'sh80000000);
		add_tick(16'sd100, -16'sd100, 32'sh7fffffff, 32'sh80000000);
		add_tick(16'sd0, 16'sd0, 32'sh80000000, 32'sh7fffffff);
		add_tick(16'sd0, 16'sd0, 32'sh80000000, 32'sh7fffffff);
		add_tick(16'sh8000, 16'sh7fff, 32'sd0, 32'sd0);
		wait_drained();

		// Zero period, and a write to an index past the register list.
		write_reg(CFG_PERIOD, 16'd0);
		write_reg(CFG_NONE, 16'h5a5a);
		end_writes();
		add_tick(16'sd0, 16'sd0, 32'sh80000000, 32'sh7fffffff);
		add_tick(16'sd0, 16'sd0, 32'sh7fffffff, 32'sh80000000);
		wait_drained();

		// Leaving position mode keeps the position error history.
		write_reg(CFG_LIMIT, 16'd3000);
		write_reg(CFG_VEL_KP, 16'd512);
		write_reg(CFG_VEL_KI, 16'd16);
		write_reg(CFG_PERIOD, 16'd5000);
		write_reg(CFG_POS_MODE, 16'd0);
		end_writes();
		add_tick(16'sd10, -16'sd10, -32'sd4000, 32'sd4000);
		add_tick(16'sd5, 16'sd5, 32'sd0, 32'sd0);
		add_tick(-16'sd7, 16'sd3, 32'sd1234, -32'sd1234);
		wait_drained();

		write_reg(CFG_POS_MODE, 16'd1);
		write_reg(CFG_POS_KP, 16'd128);
		write_reg(CFG_POS_KI, 16'd8);
		end_writes();
		add_tick(16'sd3, -16'sd3, 32'sd500, -32'sd500);
		add_tick(16'sd3, -16'sd3, 32'sd500, -32'sd500);
		add_tick(-16'sd2, 16'sd2, 32'sd0, 32'sd0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p < PHASES / 3) begin
				send_idle = 25;
				recv_idle = 82;
			end else if (p < 2 * PHASES / 3) begin
				send_idle = 82;
				recv_idle = 25;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			mode_word = 16'($urandom_range(65535));
			mode_word[0] = p[0];
			if (p == 0) begin
				apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, mode_word);
			end else if (p == 1) begin
				apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
					mode_word);
			end else begin
				lim = ($urandom_range(2) == 0) ? 16'($urandom_range(65535))
					: 16'($urandom_range(100, 20000));
				apply_setting(pick_gain(1024), pick_gain(256), pick_gain(512), pick_gain(64),
					lim, 16'($urandom_range(1, 65535)), mode_word);
			end
			for (int i = 0; i < TICKS_PER_PHASE; i++)
				add_random_tick();
			wait_drained();
		end

		repeat (40) @(posedge clk);
		missing = expected_words.size();
		if (missing != 0)
			$display("%0d predicted words never arrived", missing);
		$display("%0d ticks sent over %0d register writes in both loop modes,", ticks_queued,
			reg_writes);
		$display("%0d output words compared, %0d field errors", words_checked, mismatches);
		if (mismatches == 0 && missing == 0)
			$display("cascaded_pi_dual_motor_pwm: match");
		else
			$display("cascaded_pi_dual_motor_pwm: mismatch");
		$finish;
	end

endmodule
